@@ hw/rtl/mcpg_pkg.sv @@
// shared types, constants and slot tables of the midpoint circle point generator
package mcpg_pkg;

  // default coordinate width and fixed widths
  localparam int unsigned MCPG_COORD_BITS = 12;
  localparam int unsigned DEC_BITS        = 16;
  localparam int unsigned COLOR_BITS      = 3;
  localparam int unsigned CFG_IDX_BITS    = 1;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned NUM_SLOTS       = 8;
  localparam int unsigned NUM_OFFS        = 4;

  // frame size after reset
  localparam int unsigned FRAME_ROWS_RST = 480;
  localparam int unsigned FRAME_COLS_RST = 640;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } cfg_reg_e;

  // input operation codes
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  // what a step emits
  typedef enum logic [1:0] {
    STEP_EMPTY  = 2'd0,
    STEP_AXIS   = 2'd1,
    STEP_DIAG   = 2'd2,
    STEP_OCTANT = 2'd3
  } step_kind_e;

  // control part of one queued step
  typedef struct packed {
    step_kind_e kind;
    logic       done;
  } step_ctl_t;

  // offsets: 0 centre+x, 1 centre-x, 2 centre+y, 3 centre-y
  localparam logic [1:0] SLOT_ROW [NUM_SLOTS] = '{
    2'd0, 2'd1, 2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3
  };
  localparam logic [1:0] SLOT_COL [NUM_SLOTS] = '{
    2'd2, 2'd2, 2'd3, 2'd3, 2'd0, 2'd0, 2'd1, 2'd1
  };

  // slots in use for each kind of step, bit k is slot k
  function automatic logic [NUM_SLOTS-1:0] slot_enable(step_kind_e kind);
    logic [NUM_SLOTS-1:0] en;
    unique case (kind)
      STEP_AXIS:   en = 8'h35;
      STEP_DIAG:   en = 8'h0f;
      STEP_OCTANT: en = 8'hff;
      default:     en = '0;
    endcase
    return en;
  endfunction

endpackage

@@ hw/rtl/mcpg_if.sv @@
// handshake channels of the midpoint circle point generator

// input item channel
interface mcpg_in_if
  import mcpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = MCPG_COORD_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] center_row;
  logic [COORD_BITS-1:0] center_col;
  logic [COORD_BITS-1:0] radius;
  logic [COLOR_BITS-1:0] color;

  modport source (output valid, op, center_row, center_col, radius, color, input ready);
  modport sink   (input valid, op, center_row, center_col, radius, color, output ready);
endinterface

// result channel
interface mcpg_out_if
  import mcpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = MCPG_COORD_BITS
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_row;
  logic [COORD_BITS-1:0] pixel_col;
  logic [COLOR_BITS-1:0] pixel_color;
  logic                  pixel_valid;
  logic                  last_of_run;
  logic                  done_res;

  modport source (output valid, pixel_row, pixel_col, pixel_color, pixel_valid,
                  last_of_run, done_res, input ready);
  modport sink   (input valid, pixel_row, pixel_col, pixel_color, pixel_valid,
                  last_of_run, done_res, output ready);
endinterface

// configuration write channel
interface mcpg_cfg_if
  import mcpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = MCPG_COORD_BITS
) ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COORD_BITS:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/mcpg_front.sv @@
// front end: accepts items, walks the circle state and queues one step per beat
module mcpg_front
  import mcpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = MCPG_COORD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mcpg_in_if.sink               in_i,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output step_ctl_t             push_ctl_o,
  output logic [COORD_BITS-1:0] push_row_o,
  output logic [COORD_BITS-1:0] push_col_o,
  output logic [COLOR_BITS-1:0] push_color_o,
  output logic [COORD_BITS-1:0] push_x_o,
  output logic [COORD_BITS-1:0] push_y_o
);

  localparam int unsigned XY_W = COORD_BITS + 1;

  logic                  accept;
  logic [XY_W-1:0]       x_q, x_d, y_q, y_d, x_inc, y_dec;
  logic [DEC_BITS-1:0]   dec_q, dec_d, x_ext, y_ext;
  logic [COORD_BITS-1:0] row_q, row_d, col_q, col_d;
  logic [COLOR_BITS-1:0] color_q, color_d;
  logic                  active_q, active_d;
  step_kind_e            kind;

  assign accept       = in_i.valid && push_ready_i;
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  // next circle state, as if the beat is taken
  always_comb begin
    row_d    = row_q;
    col_d    = col_q;
    color_d  = color_q;
    x_d      = x_q;
    y_d      = y_q;
    dec_d    = dec_q;
    active_d = active_q;
    kind     = STEP_EMPTY;
    x_inc    = x_q + XY_W'(1);
    y_dec    = y_q - XY_W'(1);
    x_ext    = DEC_BITS'(x_inc);
    y_ext    = DEC_BITS'(y_dec);
    if (in_i.op == OP_START) begin
      row_d   = in_i.center_row;
      col_d   = in_i.center_col;
      color_d = in_i.color;
      x_d     = '0;
      y_d     = XY_W'(in_i.radius);
      if (in_i.radius == '0) begin
        dec_d    = DEC_BITS'(1);
        active_d = 1'b0;
      end else begin
        dec_d    = DEC_BITS'(1) - DEC_BITS'(in_i.radius);
        active_d = 1'b1;
        kind     = STEP_AXIS;
      end
    end else if (!active_q || x_q >= y_q) begin
      active_d = 1'b0;
    end else begin
      x_d = x_inc;
      if (dec_q[DEC_BITS-1]) begin
        dec_d = dec_q + ((x_ext + DEC_BITS'(1)) << 1);
      end else begin
        y_d   = y_dec;
        dec_d = dec_q + ((x_ext - y_ext) << 1) + DEC_BITS'(1);
      end
      active_d = (x_d < y_d);
      if (x_d < y_d) begin
        kind = STEP_OCTANT;
      end else if (x_d == y_d) begin
        kind = STEP_DIAG;
      end
    end
  end

  // step handed to the queue
  assign push_ctl_o   = '{kind: kind, done: !active_d};
  assign push_row_o   = row_d;
  assign push_col_o   = col_d;
  assign push_color_o = color_d;
  assign push_x_o     = x_d[COORD_BITS-1:0];
  assign push_y_o     = y_d[COORD_BITS-1:0];

  // circle state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q      <= '0;
      y_q      <= '0;
      dec_q    <= '0;
      row_q    <= '0;
      col_q    <= '0;
      color_q  <= '0;
      active_q <= 1'b0;
    end else if (accept) begin
      x_q      <= x_d;
      y_q      <= y_d;
      dec_q    <= dec_d;
      row_q    <= row_d;
      col_q    <= col_d;
      color_q  <= color_d;
      active_q <= active_d;
    end
  end

  // a circle in progress always has x below y
  a_active_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (x_q < y_q))
    else $error("active circle with x not below y");

  // a start of radius zero leaves no circle in progress
  a_zero_radius: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.op == OP_START && in_i.radius == '0) |=> !active_q)
    else $error("zero radius start left circle active");

endmodule

@@ hw/rtl/mcpg_queue.sv @@
// short step queue between front and back ends
module mcpg_queue
  import mcpg_pkg::*;
#(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue overfilled");

  // fill count rises by one on a push without a pop
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("queue count lost a push");

endmodule

@@ hw/rtl/mcpg_back.sv @@
// back end: clips the points of a step and sends one pixel per beat
module mcpg_back
  import mcpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = MCPG_COORD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mcpg_cfg_if.sink              cfg_i,
  mcpg_out_if.source            out_o,
  input  logic                  pop_valid_i,
  output logic                  pop_ready_o,
  input  step_ctl_t             pop_ctl_i,
  input  logic [COORD_BITS-1:0] pop_row_i,
  input  logic [COORD_BITS-1:0] pop_col_i,
  input  logic [COLOR_BITS-1:0] pop_color_i,
  input  logic [COORD_BITS-1:0] pop_x_i,
  input  logic [COORD_BITS-1:0] pop_y_i
);

  localparam int unsigned RV_W = COORD_BITS + 2;
  localparam int unsigned FR_W = COORD_BITS + 1;

  // frame size registers
  logic [FR_W-1:0] frame_rows_q, frame_cols_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_rows_q <= FR_W'(FRAME_ROWS_RST);
      frame_cols_q <= FR_W'(FRAME_COLS_RST);
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_FRAME_ROWS: frame_rows_q <= cfg_i.data;
        REG_FRAME_COLS: frame_cols_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // candidate rows and columns of the queue head, with clip tests
  logic [RV_W-1:0]      rv [NUM_OFFS];
  logic [RV_W-1:0]      cv [NUM_OFFS];
  logic [NUM_OFFS-1:0]  row_ok, col_ok;
  logic [NUM_SLOTS-1:0] enable, keep;

  always_comb begin
    rv[0] = RV_W'(pop_row_i) + RV_W'(pop_x_i);
    rv[1] = RV_W'(pop_row_i) - RV_W'(pop_x_i);
    rv[2] = RV_W'(pop_row_i) + RV_W'(pop_y_i);
    rv[3] = RV_W'(pop_row_i) - RV_W'(pop_y_i);
    cv[0] = RV_W'(pop_col_i) + RV_W'(pop_x_i);
    cv[1] = RV_W'(pop_col_i) - RV_W'(pop_x_i);
    cv[2] = RV_W'(pop_col_i) + RV_W'(pop_y_i);
    cv[3] = RV_W'(pop_col_i) - RV_W'(pop_y_i);
    for (int i = 0; i < NUM_OFFS; i++) begin
      row_ok[i] = !rv[i][RV_W-1] && !rv[i][COORD_BITS]
                  && ({1'b0, rv[i][COORD_BITS-1:0]} < frame_rows_q);
      col_ok[i] = !cv[i][RV_W-1] && !cv[i][COORD_BITS]
                  && ({1'b0, cv[i][COORD_BITS-1:0]} < frame_cols_q);
    end
    enable = slot_enable(pop_ctl_i.kind);
    for (int k = 0; k < NUM_SLOTS; k++) begin
      keep[k] = enable[k] && row_ok[SLOT_ROW[k]] && col_ok[SLOT_COL[k]];
    end
  end

  // step being sent out
  logic                  work_valid_q;
  logic [NUM_SLOTS-1:0]  pend_q, cur, rest;
  logic [COORD_BITS-1:0] work_row_q [NUM_OFFS];
  logic [COORD_BITS-1:0] work_col_q [NUM_OFFS];
  logic [COLOR_BITS-1:0] work_color_q;
  logic                  work_done_q;
  logic                  out_free, emit, last, load;
  logic [COORD_BITS-1:0] sel_row, sel_col;

  assign out_free    = !out_o.valid || out_o.ready;
  assign emit        = work_valid_q && out_free;
  assign cur         = pend_q & (~pend_q + NUM_SLOTS'(1));
  assign rest        = pend_q & ~cur;
  assign last        = (rest == '0);
  assign pop_ready_o = !work_valid_q || (emit && last);
  assign load        = pop_valid_i && pop_ready_o;

  // pick the lowest pending slot
  always_comb begin
    sel_row = '0;
    sel_col = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (cur[k]) begin
        sel_row = sel_row | work_row_q[SLOT_ROW[k]];
        sel_col = sel_col | work_col_q[SLOT_COL[k]];
      end
    end
  end

  // work register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      pend_q       <= '0;
    end else if (load) begin
      work_valid_q <= 1'b1;
      pend_q       <= keep;
    end else if (emit) begin
      pend_q <= rest;
      if (last) begin
        work_valid_q <= 1'b0;
      end
    end
  end

  // work register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < NUM_OFFS; i++) begin
        work_row_q[i] <= rv[i][COORD_BITS-1:0];
        work_col_q[i] <= cv[i][COORD_BITS-1:0];
      end
      work_color_q <= pop_color_i;
      work_done_q  <= pop_ctl_i.done;
    end
  end

  // output register
  logic                  out_valid_q;
  logic [COORD_BITS-1:0] out_row_q, out_col_q;
  logic [COLOR_BITS-1:0] out_color_q;
  logic                  out_pix_q, out_last_q, out_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_row_q   <= sel_row;
      out_col_q   <= sel_col;
      out_color_q <= (pend_q != '0) ? work_color_q : '0;
      out_pix_q   <= (pend_q != '0);
      out_last_q  <= last;
      out_done_q  <= work_done_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_row   = out_row_q;
  assign out_o.pixel_col   = out_col_q;
  assign out_o.pixel_color = out_color_q;
  assign out_o.pixel_valid = out_pix_q;
  assign out_o.last_of_run = out_last_q;
  assign out_o.done_res    = out_done_q;

  // an empty result always closes its run
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.pixel_valid) |-> out_o.last_of_run)
    else $error("empty result not marked last");

  // nothing is emitted without a step in the work register
  a_emit_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!work_valid_q && !$past(emit)) |-> (out_o.valid == ($past(out_o.valid)
      && !$past(out_o.ready))))
    else $error("result appeared without work");

endmodule

@@ hw/rtl/midpoint_circle_point_generator.sv @@
// top level of the midpoint circle point generator
// A start beat loads centre, radius and colour and yields the axis points of the first
// step; each advance beat runs one midpoint step and yields its symmetric points, with
// points outside the frame dropped and a single empty result where none survive. The
// front end takes one input beat per cycle while its four-entry step queue has room;
// the back end sends one pixel per cycle unless the output stalls, one result per kept point
// (eight at most, one for an empty step), and that output port sets the sustained rate.
// Configuration writes are taken in any cycle and must only be made while idle.
module midpoint_circle_point_generator
  import mcpg_pkg::*;
#(
  parameter int unsigned COORD_BITS = MCPG_COORD_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mcpg_cfg_if.sink   cfg_chan_i,
  mcpg_in_if.sink    in_chan_i,
  mcpg_out_if.source out_chan_o
);

  localparam int unsigned STEP_W = $bits(step_ctl_t) + 4 * COORD_BITS + COLOR_BITS;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  step_ctl_t             push_ctl, pop_ctl;
  logic [COORD_BITS-1:0] push_row, push_col, push_x, push_y;
  logic [COORD_BITS-1:0] pop_row, pop_col, pop_x, pop_y;
  logic [COLOR_BITS-1:0] push_color, pop_color;
  logic [STEP_W-1:0]     push_data, pop_data;

  // step packing across the queue
  assign push_data = {push_ctl, push_row, push_col, push_color, push_x, push_y};
  assign {pop_ctl, pop_row, pop_col, pop_color, pop_x, pop_y} = pop_data;

  mcpg_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_chan_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_ctl_o   (push_ctl),
    .push_row_o   (push_row),
    .push_col_o   (push_col),
    .push_color_o (push_color),
    .push_x_o     (push_x),
    .push_y_o     (push_y)
  );

  mcpg_queue #(
    .DATA_W (STEP_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  mcpg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_chan_i),
    .out_o       (out_chan_o),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_ctl_i   (pop_ctl),
    .pop_row_i   (pop_row),
    .pop_col_i   (pop_col),
    .pop_color_i (pop_color),
    .pop_x_i     (pop_x),
    .pop_y_i     (pop_y)
  );

endmodule
